FILE: rtl/pfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types, command codes and device geometry tables for the paged
// flash log writer.
// ----------------------------------------------------------------------------
package pfl_pkg;

    localparam int PFL_DEVICE_KINDS = 8;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SEEK  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // flash command codes
    localparam logic [2:0] CMD_BUF_WRITE = 3'd0;
    localparam logic [2:0] CMD_PROGRAM   = 3'd1;
    localparam logic [2:0] CMD_LOAD      = 3'd2;
    localparam logic [2:0] CMD_PAD       = 3'd3;
    localparam logic [2:0] CMD_FULL      = 3'd4;
    localparam logic [2:0] CMD_NOTHING   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_DEVICE_INDEX = 2'd0;
    localparam logic [1:0] CFG_BINARY_PAGE  = 2'd1;
    localparam logic [1:0] CFG_INITIAL_USED = 2'd2;

    localparam logic [10:0] PFL_BINARY_BASE = 11'd256;
    localparam logic [7:0]  PFL_PAD_BYTE    = 8'hFF;

    localparam logic [10:0] PFL_PAGE_SIZE [8] =
        '{11'd264, 11'd264, 11'd264, 11'd264, 11'd264, 11'd528, 11'd528, 11'd1056};
    localparam logic [3:0] PFL_COUNT_LOG2 [8] =
        '{4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};
    localparam logic [1:0] PFL_SHIFT [8] =
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};

    typedef struct packed {
        logic [2:0]  cmd;
        logic        buf_sel;
        logic [13:0] page;
        logic [15:0] dev_addr;
        logic [10:0] off;
        logic [7:0]  data;
        logic [7:0]  cnt;
    } t_res;

    typedef struct packed {
        logic        done;
        logic [23:0] quotient;
        logic [10:0] remainder;
    } t_div_res;

    function automatic logic [2:0] pfl_kind(input logic [2:0] dev);
        if (int'(dev) >= PFL_DEVICE_KINDS) begin
            return 3'(PFL_DEVICE_KINDS - 1);
        end
        return dev;
    endfunction

    function automatic logic [10:0] pfl_page_size(input logic [2:0] kind,
                                                  input logic bin);
        if (bin) begin
            return PFL_BINARY_BASE << PFL_SHIFT[kind];
        end
        return PFL_PAGE_SIZE[kind];
    endfunction

    function automatic logic [23:0] pfl_total(input logic [2:0] kind, input logic bin);
        return 24'(pfl_page_size(kind, bin)) << PFL_COUNT_LOG2[kind];
    endfunction

    function automatic logic [15:0] pfl_dev_addr(input logic [15:0] page,
                                                 input logic [2:0] kind,
                                                 input logic bin);
        logic [2:0] s;
        s = {1'b0, PFL_SHIFT[kind]} + {2'b00, ~bin};
        return page << s;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pfl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfl_div
// Restoring divider, one quotient bit per cycle, splits a byte address into
// page number and page offset.
// ----------------------------------------------------------------------------
module pfl_div
    import pfl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [23:0] i_dividend,
    input  wire logic [10:0] i_divisor,
    output t_div_res         o_res
);

    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [10:0]      r_rem;
    logic [23:0]      r_quo;
    logic [10:0]      r_dvs;

    logic [11:0] w_trial;
    logic [11:0] w_diff;
    logic        w_ge;
    logic [10:0] n_rem;

    assign w_trial = {r_rem, r_quo[23]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign n_rem   = w_ge ? w_diff[10:0] : w_trial[10:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[22:0], w_ge};
        end else if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_dvs != '0 |-> r_rem < r_dvs)
        else $error("partial remainder not below divisor");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("done without a finished run");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !r_busy |=> r_busy)
        else $error("start did not launch a run");

endmodule
`default_nettype wire

FILE: rtl/paged_flash_log_writer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_flash_log_writer_unit
// Turns write, seek and flush requests for a paged serial flash into buffer
// write, program, load and pad commands, double-buffered over two SRAMs.
//
//   channel  direction  handshake                  beat
//   input    in         i_in_valid / o_in_ready    operation, byte, final, position
//   result   out        o_out_valid / i_out_ready  one flash command
//   config   in         i_cfg_valid / o_cfg_ready  register index and data
//
// A write or flush passes through the calc step and then emits 1 to 2 results.
// A seek also runs the 24-step address divider before its results are emitted.
// The next beat is taken once the last result is in the output register.
// Reset is synchronous; the result channel may stall at any time.
// ----------------------------------------------------------------------------
module paged_flash_log_writer_unit
    import pfl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_final_byte,
    input  wire logic [23:0] i_position,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_command,
    output logic             o_buffer_select,
    output logic [13:0]      o_page_number,
    output logic [15:0]      o_device_address,
    output logic [10:0]      o_offset,
    output logic [7:0]       o_out_byte,
    output logic [7:0]       o_accepted_count,
    output logic [23:0]      o_used_bytes,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam t_res RES_NONE = '{cmd: CMD_NOTHING, default: '0};

    logic [1:0]  r_state, n_state;
    logic [2:0]  r_dev_index;
    logic        r_binary;

    logic [23:0] r_cur_byte;
    logic [10:0] r_page_off;
    logic [15:0] r_cur_page;
    logic        r_toggle;
    logic        r_dirty;
    logic [23:0] r_used;
    logic [7:0]  r_call_cnt;

    logic [1:0]  r_op;
    logic [7:0]  r_data;
    logic        r_fin;
    logic [23:0] r_pos;

    t_res        r_res [3];
    logic [1:0]  r_nres;
    logic [1:0]  r_idx;

    logic        r_out_valid;
    t_res        r_out;
    logic [23:0] r_out_used;
    logic        r_out_last;

    logic [2:0]  w_kind;
    logic [10:0] w_psize;
    logic [23:0] w_total;
    logic        w_accept;
    logic        w_out_free;
    logic        w_full;
    logic [7:0]  w_cc1;
    logic [7:0]  w_cnt;
    logic        w_page_end;
    t_res        w_res0;
    t_res        w_res1;
    logic [1:0]  w_calc_nres;
    logic        w_div_start;
    t_div_res    w_div;
    logic [15:0] w_new_page;
    logic        w_page_chg;
    logic        w_emit_last;

    assign w_kind     = pfl_kind(r_dev_index);
    assign w_psize    = pfl_page_size(w_kind, r_binary);
    assign w_total    = pfl_total(w_kind, r_binary);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_full      = r_cur_byte >= w_total;
    assign w_cc1       = r_call_cnt + 8'd1;
    assign w_cnt       = r_fin ? (w_full ? r_call_cnt : w_cc1) : 8'd0;
    assign w_page_end  = ({1'b0, r_page_off} + 12'd1) >= {1'b0, w_psize};
    assign w_div_start = (r_state == S_CALC) && (r_op == OP_SEEK);
    assign w_new_page  = w_div.quotient[15:0];
    assign w_page_chg  = w_new_page != r_cur_page;
    assign w_emit_last = r_idx == (r_nres - 2'd1);

    // results built in the calc step
    always_comb begin
        w_res0      = RES_NONE;
        w_res1      = RES_NONE;
        w_calc_nres = 2'd1;
        case (r_op)
            OP_WRITE: begin
                if (w_full) begin
                    w_res0.cmd = CMD_FULL;
                    w_res0.cnt = w_cnt;
                end else begin
                    w_res0.cmd     = CMD_BUF_WRITE;
                    w_res0.buf_sel = r_toggle;
                    w_res0.off     = r_page_off;
                    w_res0.data    = r_data;
                    w_res0.cnt     = w_cnt;
                    if (w_page_end) begin
                        w_res1.cmd      = CMD_PROGRAM;
                        w_res1.buf_sel  = r_toggle;
                        w_res1.page     = r_cur_page[13:0];
                        w_res1.dev_addr = pfl_dev_addr(r_cur_page, w_kind, r_binary);
                        w_res1.cnt      = w_cnt;
                        w_calc_nres     = 2'd2;
                    end
                end
            end
            OP_SEEK, OP_FLUSH: begin
                if (r_dirty) begin
                    w_res0.cmd      = CMD_PAD;
                    w_res0.buf_sel  = r_toggle;
                    w_res0.off      = r_page_off;
                    w_res0.data     = PFL_PAD_BYTE;
                    w_res1.cmd      = CMD_PROGRAM;
                    w_res1.buf_sel  = r_toggle;
                    w_res1.page     = r_cur_page[13:0];
                    w_res1.dev_addr = pfl_dev_addr(r_cur_page, w_kind, r_binary);
                    w_calc_nres     = 2'd2;
                end else if (r_op == OP_SEEK) begin
                    w_calc_nres = 2'd0;
                end
            end
            default: begin
                w_calc_nres = 2'd1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = (r_op == OP_SEEK) ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dev_index <= '0;
            r_binary    <= 1'b0;
            r_cur_byte  <= '0;
            r_page_off  <= '0;
            r_cur_page  <= '1;
            r_toggle    <= 1'b0;
            r_dirty     <= 1'b0;
            r_used      <= '0;
            r_call_cnt  <= '0;
            r_nres      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEVICE_INDEX: r_dev_index <= i_cfg_data[2:0];
                    CFG_BINARY_PAGE:  r_binary    <= i_cfg_data[0];
                    CFG_INITIAL_USED: r_used      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CALC: begin
                    r_nres <= w_calc_nres;
                    r_idx  <= '0;
                    if (r_op == OP_WRITE) begin
                        if (r_fin) begin
                            r_call_cnt <= '0;
                        end else if (!w_full) begin
                            r_call_cnt <= w_cc1;
                        end
                        if (!w_full) begin
                            r_dirty    <= 1'b1;
                            r_cur_byte <= r_cur_byte + 24'd1;
                            if (w_page_end) begin
                                r_toggle   <= ~r_toggle;
                                r_cur_page <= r_cur_page + 16'd1;
                                r_page_off <= '0;
                            end else begin
                                r_page_off <= r_page_off + 11'd1;
                            end
                        end
                    end else if ((r_op == OP_SEEK || r_op == OP_FLUSH) && r_dirty) begin
                        r_dirty <= 1'b0;
                        if (r_used < r_cur_byte) begin
                            r_used <= r_cur_byte;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_cur_byte <= r_pos;
                        r_page_off <= w_div.remainder;
                        if (r_used < r_pos) begin
                            r_used <= r_pos;
                        end
                        if (w_page_chg) begin
                            r_cur_page <= w_new_page;
                            r_nres     <= r_nres + 2'd1;
                        end else if (r_nres == 2'd0) begin
                            r_nres <= 2'd1;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_idx       <= r_idx + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload: latched beat, result slots, output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_operation;
            r_data <= i_data_byte;
            r_fin  <= i_final_byte;
            r_pos  <= (i_position > w_total) ? w_total : i_position;
        end
        if (r_state == S_CALC) begin
            r_res[0] <= w_res0;
            r_res[1] <= w_res1;
        end
        if (r_state == S_DIV && w_div.done) begin
            if (w_page_chg) begin
                r_res[r_nres] <= '{cmd: CMD_LOAD, buf_sel: r_toggle,
                                   page: w_new_page[13:0],
                                   dev_addr: pfl_dev_addr(w_new_page, w_kind, r_binary),
                                   default: '0};
            end else if (r_nres == 2'd0) begin
                r_res[0] <= RES_NONE;
            end
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out      <= r_res[r_idx];
            r_out_used <= r_used;
            r_out_last <= w_emit_last;
        end
    end

    pfl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_pos),
        .i_divisor  (w_psize),
        .o_res      (w_div)
    );

    assign o_out_valid      = r_out_valid;
    assign o_command        = r_out.cmd;
    assign o_buffer_select  = r_out.buf_sel;
    assign o_page_number    = r_out.page;
    assign o_device_address = r_out.dev_addr;
    assign o_offset         = r_out.off;
    assign o_out_byte       = r_out.data;
    assign o_accepted_count = r_out.cnt;
    assign o_used_bytes     = r_out_used;
    assign o_last           = r_out_last;

    a_div_only_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_op == OP_SEEK)
        else $error("divider wait outside a seek");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divider finished while not awaited");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_nres != 2'd0 && r_idx < r_nres)
        else $error("result slot index out of range");

endmodule
`default_nettype wire
